/* design/scl_pkg.sv */
package scl_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NO_SHIFT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADF_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_UNIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PADDED_WIDTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd5;

    // Configuration register set
    typedef struct packed {
        logic        no_shift;
        logic        adf_mode;
        logic [2:0]  delay_unit;
        logic [10:0] image_width;
        logic [10:0] padded_width;
        logic [13:0] image_height;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        no_shift:     1'b0,
        adf_mode:     1'b0,
        delay_unit:   3'd1,
        image_width:  11'd1024,
        padded_width: 11'd1024,
        image_height: 14'd8192
    };

    // Per-pixel control from the address generator
    typedef struct packed {
        logic keep;       // pixel inside kept window, touches the line stores
        logic emit;       // pixel produces an output transaction
        logic use_mem;    // row offsets active, take delayed components
        logic row_end;
        logic frame_end;
    } t_pix_ctl;

endpackage

/* design/scl_cfg_regs.sv */
module scl_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [scl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [scl_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output scl_pkg::t_cfg                  o_cfg
);
    import scl_pkg::*;

    t_cfg r_cfg;

    // Register writes, out-of-range indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NO_SHIFT:     r_cfg.no_shift     <= i_cfg_wdata[0];
                CFG_ADF_MODE:     r_cfg.adf_mode     <= i_cfg_wdata[0];
                CFG_DELAY_UNIT:   r_cfg.delay_unit   <= i_cfg_wdata[2:0];
                CFG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_wdata[10:0];
                CFG_PADDED_WIDTH: r_cfg.padded_width <= i_cfg_wdata[10:0];
                CFG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_wdata[13:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/scl_line_store.sv */
module scl_line_store #(
    parameter int DEPTH  = 4096,
    parameter int DATA_W = 8
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [DATA_W-1:0]        i_wdata,
    output logic [DATA_W-1:0]        o_rdata
);
    logic [DATA_W-1:0] r_mem [0:DEPTH-1];
    logic [DATA_W-1:0] r_rdata;

    // Read-first single port: old entry comes out while the new one goes in
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_addr];
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/scl_addr_gen.sv */
module scl_addr_gen #(
    parameter int MAX_ROW_PIXELS = 1024,
    parameter int MAX_DELAY_UNIT = 4,
    parameter int MAX_ROWS       = 8192
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  scl_pkg::t_cfg                                         i_cfg,
    input  logic                                                  i_adv,
    output scl_pkg::t_pix_ctl                                     o_ctl,
    output logic [$clog2(4*MAX_DELAY_UNIT*MAX_ROW_PIXELS)-1:0]    o_far_addr,
    output logic [$clog2(2*MAX_DELAY_UNIT*MAX_ROW_PIXELS)-1:0]    o_mid_addr
);
    import scl_pkg::*;

    localparam int COL_W = $clog2(MAX_ROW_PIXELS);
    localparam int PW_W  = $clog2(MAX_ROW_PIXELS + 1);
    localparam int K_W   = $clog2(MAX_DELAY_UNIT + 1);
    localparam int D_W   = K_W + 2;
    localparam int H_W   = $clog2(MAX_ROWS + 1);
    localparam int ROW_W = $clog2(4*MAX_DELAY_UNIT + MAX_ROWS + 1);
    localparam int FS_W  = $clog2(4*MAX_DELAY_UNIT);
    localparam int MS_W  = $clog2(2*MAX_DELAY_UNIT);
    localparam int FA_W  = $clog2(4*MAX_DELAY_UNIT*MAX_ROW_PIXELS);
    localparam int MA_W  = $clog2(2*MAX_DELAY_UNIT*MAX_ROW_PIXELS);

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    // one row-slot counter pair per delay unit value: row mod 4k and row mod 2k
    logic [FS_W-1:0]  r_far_slot [0:MAX_DELAY_UNIT];
    logic [MS_W-1:0]  r_mid_slot [0:MAX_DELAY_UNIT];

    logic [PW_W-1:0]  pw;
    logic [PW_W-1:0]  ew;
    logic [K_W-1:0]   k;
    logic [D_W-1:0]   d;
    logic [H_W-1:0]   h;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] lim;
    logic             in_frame;
    logic             col_wrap;
    logic             row_adv;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [FS_W-1:0]  far_sel;
    logic [MS_W-1:0]  mid_sel;

    // Effective geometry from the registers
    always_comb begin
        if (i_cfg.padded_width == '0) begin
            pw = PW_W'(1);
        end else if (32'(i_cfg.padded_width) > MAX_ROW_PIXELS) begin
            pw = PW_W'(MAX_ROW_PIXELS);
        end else begin
            pw = PW_W'(i_cfg.padded_width);
        end

        if (32'(i_cfg.image_width) < 32'(pw)) begin
            ew = PW_W'(i_cfg.image_width);
        end else begin
            ew = pw;
        end

        if (i_cfg.no_shift) begin
            k = '0;
        end else if (32'(i_cfg.delay_unit) > MAX_DELAY_UNIT) begin
            k = K_W'(MAX_DELAY_UNIT);
        end else begin
            k = K_W'(i_cfg.delay_unit);
        end
        d = {k, 2'b00};

        if (32'(i_cfg.image_height) < MAX_ROWS) begin
            h = H_W'(i_cfg.image_height);
        end else begin
            h = H_W'(MAX_ROWS);
        end
    end

    // Position of the current pixel and its classification
    always_comb begin
        col      = (32'(r_col) >= 32'(pw)) ? '0 : r_col;
        lim      = ROW_W'(d) + ROW_W'(h);
        in_frame = r_row < lim;
        col_wrap = (PW_W'(col) + PW_W'(1)) >= pw;
        row_adv  = i_adv && col_wrap && in_frame;

        o_ctl.keep      = in_frame && (PW_W'(col) < ew);
        o_ctl.emit      = o_ctl.keep && (r_row >= ROW_W'(d));
        o_ctl.use_mem   = d != '0;
        o_ctl.row_end   = PW_W'(col) == (ew - PW_W'(1));
        o_ctl.frame_end = o_ctl.row_end && (r_row == (lim - ROW_W'(1)));

        n_col = col_wrap ? '0 : COL_W'(col + COL_W'(1));
        n_row = row_adv ? (r_row + ROW_W'(1)) : r_row;
    end

    // Line store addresses: slot row times row pitch plus column
    always_comb begin
        far_sel    = r_far_slot[k];
        mid_sel    = r_mid_slot[k];
        o_far_addr = FA_W'(32'(far_sel) * MAX_ROW_PIXELS + 32'(col));
        o_mid_addr = MA_W'(32'(mid_sel) * MAX_ROW_PIXELS + 32'(col));
    end

    // Counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            for (int j = 0; j <= MAX_DELAY_UNIT; j++) begin
                r_far_slot[j] <= '0;
                r_mid_slot[j] <= '0;
            end
        end else begin
            if (i_adv) begin
                r_col <= n_col;
            end
            r_row <= n_row;
            for (int j = 0; j <= MAX_DELAY_UNIT; j++) begin
                if (j == 0) begin
                    r_far_slot[j] <= '0;
                    r_mid_slot[j] <= '0;
                end else if (row_adv) begin
                    r_far_slot[j] <= (r_far_slot[j] == FS_W'(4*j - 1)) ?
                                     '0 : r_far_slot[j] + FS_W'(1);
                    r_mid_slot[j] <= (r_mid_slot[j] == MS_W'(2*j - 1)) ?
                                     '0 : r_mid_slot[j] + MS_W'(1);
                end
            end
        end
    end

    // Largest lanes wrap at their modulus
    a_far_lane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_far_slot[MAX_DELAY_UNIT]) < 4*MAX_DELAY_UNIT)
        else $error("far slot lane out of range");

    a_mid_lane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_mid_slot[MAX_DELAY_UNIT]) < 2*MAX_DELAY_UNIT)
        else $error("mid slot lane out of range");

    // Row counter moves only on an accepted pixel
    a_row_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_row))
        else $error("row counter moved without a transaction");

endmodule

/* design/scan_color_line_realign_unit.sv */
// Channel   | Valid   | Stall   | Payload
// ----------+---------+---------+-------------------------------------------------
// pixel in  | i_valid | o_stall | i_comp_first, i_comp_second, i_comp_third
// pixel out | o_valid | i_stall | o_out_first/second/third, o_row_end, o_frame_end
// config    | i_cfg_we| -       | i_cfg_idx, i_cfg_wdata
//
// One pixel per cycle while the output is not stalled; a pixel passes from input to
// output through the line store read register, then the output register.
// Each line store is one read-first port, read per kept pixel, written if use_mem.
// Sync active-low reset clears counters, config, valid bits; not data regs or stores.
// o_stall rises only while both the store read stage and output register are full.
module scan_color_line_realign_unit #(
    parameter int MAX_ROW_PIXELS = 1024,
    parameter int MAX_DELAY_UNIT = 4,
    parameter int MAX_ROWS       = 8192
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [scl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [scl_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_comp_first,
    input  logic [7:0]                     i_comp_second,
    input  logic [7:0]                     i_comp_third,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_out_first,
    output logic [7:0]                     o_out_second,
    output logic [7:0]                     o_out_third,
    output logic                           o_row_end,
    output logic                           o_frame_end
);
    import scl_pkg::*;

    localparam int FAR_DEPTH = 4 * MAX_DELAY_UNIT * MAX_ROW_PIXELS;
    localparam int MID_DEPTH = 2 * MAX_DELAY_UNIT * MAX_ROW_PIXELS;
    localparam int FA_W      = $clog2(FAR_DEPTH);
    localparam int MA_W      = $clog2(MID_DEPTH);

    t_cfg             cfg;
    t_pix_ctl         ctl;
    logic [FA_W-1:0]  far_addr;
    logic [MA_W-1:0]  mid_addr;
    logic [7:0]       far_rdata;
    logic [7:0]       mid_rdata;
    logic             in_acc;
    logic             s1_adv;
    logic             st_en;
    logic             st_we;
    logic [7:0]       far_wdata;

    // Stage 1: store read data plus bypassed components
    logic             r_s1_valid;
    logic [7:0]       r_s1_c0;
    logic [7:0]       r_s1_c1;
    logic [7:0]       r_s1_c2;
    logic             r_s1_use_mem;
    logic             r_s1_adf;
    logic             r_s1_re;
    logic             r_s1_fe;

    // Output register
    logic             r_out_valid;
    logic [7:0]       r_out_first;
    logic [7:0]       r_out_second;
    logic [7:0]       r_out_third;
    logic             r_out_re;
    logic             r_out_fe;
    logic [7:0]       n_first;
    logic [7:0]       n_second;
    logic [7:0]       n_third;

    scl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    scl_addr_gen #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
        .MAX_DELAY_UNIT (MAX_DELAY_UNIT),
        .MAX_ROWS       (MAX_ROWS)
    ) u_addr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_adv      (in_acc),
        .o_ctl      (ctl),
        .o_far_addr (far_addr),
        .o_mid_addr (mid_addr)
    );

    // Handshake
    assign s1_adv  = !r_out_valid || !i_stall;
    assign o_stall = r_s1_valid && !s1_adv;
    assign in_acc  = i_valid && !o_stall;

    // Store access: component held back the longest goes to the far store
    assign st_en     = in_acc && ctl.keep;
    assign st_we     = st_en && ctl.use_mem;
    assign far_wdata = cfg.adf_mode ? i_comp_first : i_comp_third;

    scl_line_store #(.DEPTH(FAR_DEPTH), .DATA_W(8)) u_far (
        .i_clk   (i_clk),
        .i_en    (st_en),
        .i_we    (st_we),
        .i_addr  (far_addr),
        .i_wdata (far_wdata),
        .o_rdata (far_rdata)
    );

    scl_line_store #(.DEPTH(MID_DEPTH), .DATA_W(8)) u_mid (
        .i_clk   (i_clk),
        .i_en    (st_en),
        .i_we    (st_we),
        .i_addr  (mid_addr),
        .i_wdata (i_comp_second),
        .o_rdata (mid_rdata)
    );

    // Stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= ctl.emit;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_c0      <= i_comp_first;
            r_s1_c1      <= i_comp_second;
            r_s1_c2      <= i_comp_third;
            r_s1_use_mem <= ctl.use_mem;
            r_s1_adf     <= cfg.adf_mode;
            r_s1_re      <= ctl.row_end;
            r_s1_fe      <= ctl.frame_end;
        end
    end

    // Component merge
    always_comb begin
        n_first  = (r_s1_use_mem && r_s1_adf)  ? far_rdata : r_s1_c0;
        n_second = r_s1_use_mem                ? mid_rdata : r_s1_c1;
        n_third  = (r_s1_use_mem && !r_s1_adf) ? far_rdata : r_s1_c2;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_first  <= n_first;
            r_out_second <= n_second;
            r_out_third  <= n_third;
            r_out_re     <= r_s1_re;
            r_out_fe     <= r_s1_fe;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_first  = r_out_first;
    assign o_out_second = r_out_second;
    assign o_out_third  = r_out_third;
    assign o_row_end    = r_out_re;
    assign o_frame_end  = r_out_fe;

    // Last pixel of the frame also closes its row
    a_frame_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fe) |-> r_out_re)
        else $error("frame end without row end");

    // Input held off only while stage 1 and the output register both carry a pixel
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid))
        else $error("stall without full pipeline");

    // A blocked stage 1 keeps its pixel
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_c1)))
        else $error("stage 1 pixel lost under stall");

endmodule

/* verif/scan_color_line_realign_unit_test.sv */
`timescale 1ns / 100ps

module scan_color_line_realign_unit_test;
    import scl_pkg::*;

    localparam int ROW_PIXELS_CAP = 1024;
    localparam int DELAY_UNIT_CAP = 4;
    localparam int ROWS_CAP       = 8192;
    localparam int FAR_SLOTS      = 4 * DELAY_UNIT_CAP * ROW_PIXELS_CAP;
    localparam int MID_SLOTS      = 2 * DELAY_UNIT_CAP * ROW_PIXELS_CAP;
    // The first frame runs at the largest offset over this many columns, so that
    // every store entry a later frame can read has been written by then.
    localparam int FILL_COLS      = 8;
    localparam int DRAIN_CYCLES   = 8;
    localparam int STUCK_LIMIT    = 2000;
    localparam int RANDOM_ITEMS   = 100;

    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
    } t_raw_pix;

    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic       row_end;
        logic       frame_end;
    } t_rgb_pix;

    // DUT connections
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  i_valid       = 1'b0;
    logic                  o_stall;
    logic [7:0]            i_comp_first  = '0;
    logic [7:0]            i_comp_second = '0;
    logic [7:0]            i_comp_third  = '0;
    logic                  o_valid;
    logic                  i_stall       = 1'b0;
    logic [7:0]            o_out_first;
    logic [7:0]            o_out_second;
    logic [7:0]            o_out_third;
    logic                  o_row_end;
    logic                  o_frame_end;

    // Realignment state mirrored by the predictor
    t_cfg        shadow_cfg = CFG_RESET;
    logic [7:0]  far_line [FAR_SLOTS];
    logic [7:0]  mid_line [MID_SLOTS];
    int unsigned col_ptr = 0;
    int unsigned row_ptr = 0;

    // Traffic bookkeeping
    t_raw_pix    raw_pending [$];
    t_rgb_pix    aligned_due [$];
    t_raw_pix    next_px;
    int          items_queued = 0;
    int          items_taken  = 0;
    int          pix_out_cnt  = 0;
    int          mismatches   = 0;
    int          stuck_cycles = 0;
    bit          in_taken     = 1'b0;
    bit          calm         = 1'b0;
    int unsigned src_odds     = 0;
    int unsigned sink_odds    = 0;
    int unsigned src_gap      = 0;
    int unsigned sink_hold    = 0;

    logic [7:0] corner_bytes [12] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80,
                                      8'h7F, 8'hFE, 8'h0F, 8'hF0, 8'h3C, 8'hC3};

    scan_color_line_realign_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_comp_first  (i_comp_first),
        .i_comp_second (i_comp_second),
        .i_comp_third  (i_comp_third),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_first   (o_out_first),
        .o_out_second  (o_out_second),
        .o_out_third   (o_out_third),
        .o_row_end     (o_row_end),
        .o_frame_end   (o_frame_end)
    );

    always #4 i_clk = ~i_clk;

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("mismatch: %s", what);
    endtask

    // One raw pixel through the line delays; returns 1 when it yields an output pixel
    function automatic bit realign_pixel(input t_raw_pix px, output t_rgb_pix res);
        int unsigned pw, ew, k, d, h, col, row, fi, mi;
        logic [7:0]  far_old, mid_old;
        bit          hit;
        hit = 1'b0;
        pw = shadow_cfg.padded_width;
        if (pw < 1) pw = 1;
        if (pw > ROW_PIXELS_CAP) pw = ROW_PIXELS_CAP;
        ew = (shadow_cfg.image_width < pw) ? shadow_cfg.image_width : pw;
        k = shadow_cfg.no_shift ? 0 : shadow_cfg.delay_unit;
        if (k > DELAY_UNIT_CAP) k = DELAY_UNIT_CAP;
        d = 4 * k;
        h = (shadow_cfg.image_height < ROWS_CAP) ? shadow_cfg.image_height : ROWS_CAP;
        col = (col_ptr >= pw) ? 0 : col_ptr;
        row = row_ptr;
        res.c0 = px.c0;
        res.c1 = px.c1;
        res.c2 = px.c2;
        res.row_end = 1'b0;
        res.frame_end = 1'b0;
        if (row < d + h && col < ew) begin
            if (d != 0) begin
                fi = (row % d) * ROW_PIXELS_CAP + col;
                mi = (row % (2 * k)) * ROW_PIXELS_CAP + col;
                far_old = far_line[fi];
                mid_old = mid_line[mi];
                far_line[fi] = shadow_cfg.adf_mode ? px.c0 : px.c2;
                mid_line[mi] = px.c1;
                res.c1 = mid_old;
                if (shadow_cfg.adf_mode) res.c0 = far_old;
                else res.c2 = far_old;
            end
            if (row >= d) begin
                res.row_end = (col == ew - 1);
                res.frame_end = res.row_end && (row - d == h - 1);
                hit = 1'b1;
            end
        end
        if (col + 1 >= pw) begin
            col = 0;
            if (row < d + h) row++;
        end else begin
            col++;
        end
        col_ptr = col;
        row_ptr = row;
        return hit;
    endfunction

    function automatic int unsigned idle_odds();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 3;
            default: return 10;
        endcase
    endfunction

    // Pixel source: holds each transaction until taken, idles in bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (src_gap != 0) begin
                src_gap--;
                i_valid <= 1'b0;
            end else if (src_odds != 0 && raw_pending.size() != 0 &&
                         $urandom_range(1, src_odds) == 1) begin
                src_gap = $urandom_range(0, 4);
                i_valid <= 1'b0;
            end else if (raw_pending.size() != 0) begin
                next_px = raw_pending.pop_front();
                i_valid       <= 1'b1;
                i_comp_first  <= next_px.c0;
                i_comp_second <= next_px.c1;
                i_comp_third  <= next_px.c2;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Output sink stall bursts
    always @(negedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold--;
            i_stall <= 1'b1;
        end else if (sink_odds != 0 && $urandom_range(1, sink_odds) == 1) begin
            sink_hold = $urandom_range(0, 4);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Check output transactions, then predict from the accepted input one
    always @(posedge i_clk) begin : monitor
        t_rgb_pix got;
        t_rgb_pix want;
        t_raw_pix px;
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            got.c0 = o_out_first;
            got.c1 = o_out_second;
            got.c2 = o_out_third;
            got.row_end = o_row_end;
            got.frame_end = o_frame_end;
            if (aligned_due.size() == 0) begin
                flag_mismatch($sformatf("pixel %0d unexpected: %h %h %h row_end=%b frame_end=%b",
                    pix_out_cnt, got.c0, got.c1, got.c2, got.row_end, got.frame_end));
            end else begin
                want = aligned_due.pop_front();
                if (got !== want) begin
                    flag_mismatch($sformatf(
                        "pixel %0d got %h %h %h %b %b, want %h %h %h %b %b", pix_out_cnt,
                        got.c0, got.c1, got.c2, got.row_end, got.frame_end,
                        want.c0, want.c1, want.c2, want.row_end, want.frame_end));
                end
            end
            pix_out_cnt++;
        end
        if (i_rst_n && i_valid && !o_stall) begin
            px.c0 = i_comp_first;
            px.c1 = i_comp_second;
            px.c2 = i_comp_third;
            items_taken++;
            if (realign_pixel(px, want)) aligned_due.push_back(want);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_NO_SHIFT:     shadow_cfg.no_shift     = value[0];
            CFG_ADF_MODE:     shadow_cfg.adf_mode     = value[0];
            CFG_DELAY_UNIT:   shadow_cfg.delay_unit   = value[2:0];
            CFG_IMAGE_WIDTH:  shadow_cfg.image_width  = value[10:0];
            CFG_PADDED_WIDTH: shadow_cfg.padded_width = value[10:0];
            CFG_IMAGE_HEIGHT: shadow_cfg.image_height = value[13:0];
            default: ;
        endcase
    endtask

    task automatic program_phase(input bit ns, input bit adf, input int unsigned ku,
                                 input int unsigned ew, input int unsigned pw,
                                 input int unsigned h);
        write_reg(CFG_NO_SHIFT, 32'(ns));
        write_reg(CFG_ADF_MODE, 32'(adf));
        write_reg(CFG_DELAY_UNIT, ku);
        write_reg(CFG_IMAGE_WIDTH, ew);
        write_reg(CFG_PADDED_WIDTH, pw);
        write_reg(CFG_IMAGE_HEIGHT, h);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Queue n pixels; the first n_fixed take corner byte patterns
    task automatic feed(input int n, input int n_fixed);
        t_raw_pix px;
        @(posedge i_clk);
        src_odds  = calm ? 0 : idle_odds();
        sink_odds = calm ? 0 : idle_odds();
        for (int i = 0; i < n; i++) begin
            if (i < n_fixed) begin
                px.c0 = corner_bytes[i % 12];
                px.c1 = corner_bytes[(i + 4) % 12];
                px.c2 = corner_bytes[(i + 8) % 12];
            end else begin
                px.c0 = $urandom_range(0, 255);
                px.c1 = $urandom_range(0, 255);
                px.c2 = $urandom_range(0, 255);
            end
            raw_pending.push_back(px);
        end
        items_queued += n;
    endtask

    // Wait until all pixels are taken and all outputs seen, then let the pipe empty
    task automatic settle();
        @(negedge i_clk);
        while (items_taken != items_queued || aligned_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned pw, pw_eff, ew, ew_cap, ku, rows, n, d, h, pick, random_items;
        bit          ns, adf;
        random_items = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Fill: largest offset, 16 rows of history, then four output rows and a
        // few pixels past the end of the frame
        program_phase(1'b0, 1'b0, DELAY_UNIT_CAP, FILL_COLS, FILL_COLS, 4);
        feed(20 * FILL_COLS + 3, 0);
        settle();

        // Document feeder order; narrower row leaves the column counter past it;
        // image width above the padded width
        program_phase(1'b0, 1'b1, 2, 2047, 2, row_ptr - 8 + 6);
        feed(13, 0);
        settle();

        // Zero delay unit, zero padded width; corner patterns pass straight through
        program_phase(1'b0, 1'b0, 0, 1, 0, row_ptr + 12);
        feed(14, 12);
        settle();

        // Zero image width: rows advance, nothing comes out
        program_phase(1'b0, 1'b0, 1, 0, 5, row_ptr - 4 + 3);
        feed(15, 0);
        settle();

        // Zero image height: everything dropped
        program_phase(1'b0, 1'b1, 3, 4, 5, 0);
        feed(7, 0);
        settle();

        // Delay unit above its maximum saturates
        program_phase(1'b0, 1'b1, 7, FILL_COLS, FILL_COLS, row_ptr - 16 + 3);
        feed(26, 0);
        settle();

        // No shift with a nonzero delay unit
        program_phase(1'b1, 1'b1, 4, 3, 6, row_ptr + 2);
        feed(14, 0);
        settle();

        // Widest row, padded width above the maximum
        program_phase(1'b1, 1'b0, 4, 1024, 2047, row_ptr + 1);
        feed(ROW_PIXELS_CAP, 0);
        settle();

        // Random frames; shifted ones stay within the filled columns
        while (random_items < RANDOM_ITEMS) begin
            ns  = ($urandom_range(0, 5) == 0);
            adf = $urandom_range(0, 1);
            ku  = $urandom_range(0, 7);
            d   = ns ? 0 : 4 * ((ku > DELAY_UNIT_CAP) ? DELAY_UNIT_CAP : ku);
            case ($urandom_range(0, 9))
                0: pw = 0;
                1: pw = $urandom_range(9, 40);
                default: pw = $urandom_range(1, 8);
            endcase
            pw_eff = (pw == 0) ? 1 : pw;
            ew_cap = (d != 0 && pw_eff > FILL_COLS) ? FILL_COLS : pw_eff;
            ew = $urandom_range(1, ew_cap);
            pick = $urandom_range(0, 15);
            if (pick == 0) ew = 0;
            else if (pick == 1 && ew_cap == pw_eff) ew = 2047;
            rows = $urandom_range(1, 10);
            h = row_ptr - d + rows;
            if ($urandom_range(0, 15) == 0) h = 0;
            program_phase(ns, adf, ku, ew, pw, h);
            n = rows * pw_eff + $urandom_range(0, 3);
            feed(n, 0);
            if (ew != 0 && h != 0) random_items += n;
            settle();
        end

        // Last stretch without idling; height above the maximum clamps
        calm = 1'b1;
        program_phase(1'b0, 1'b0, DELAY_UNIT_CAP, FILL_COLS, FILL_COLS, 16383);
        feed(64, 0);
        settle();

        if (aligned_due.size() != 0) begin
            flag_mismatch($sformatf("%0d output pixels never arrived", aligned_due.size()));
        end
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
